>>> design/pdsdc_pkg.sv
// ----------------------------------------------------------------------------
// pdsdc_pkg
// Shared widths, register indexes and pipeline types of the passive DS
// damping controller.
// ----------------------------------------------------------------------------
package pdsdc_pkg;

  // Field widths
  localparam int unsigned VelW   = 24;  // Q8.16 velocity
  localparam int unsigned GainW  = 24;  // Q12.12 gain
  localparam int unsigned ForceW = 40;  // Q24.16 force
  localparam int unsigned IdxW   = 2;   // config register index

  // Internal widths
  localparam int unsigned ProdW  = 2 * VelW;       // d*v, d*d
  localparam int unsigned WW     = ProdW + 2;      // d.v, signed
  localparam int unsigned WAbsW  = ProdW;          // |d.v| <= 3*2^46
  localparam int unsigned SW     = ProdW + 1;      // |d|^2
  localparam int unsigned NumW   = 84;             // |d_i|*|w|*2^12
  localparam int unsigned QuoW   = 37;             // projection magnitude
  localparam int unsigned RemW   = SW;             // divider remainder
  localparam int unsigned DivStages = QuoW;        // one quotient bit a stage
  localparam int unsigned AccW   = 64;

  // Register indexes
  localparam logic [IdxW-1:0] RegGainAlong  = IdxW'(0);
  localparam logic [IdxW-1:0] RegGainAcross = IdxW'(1);

  localparam logic [GainW-1:0] GainReset = GainW'(409600);

  // Data that rides along the divider
  typedef struct packed {
    logic [2:0][VelW-1:0] meas;
    logic [2:0][VelW-1:0] goal;
    logic [2:0]           neg;
    logic                 zero;
  } side_t;

endpackage

>>> design/pdsdc_in_if.sv
// ----------------------------------------------------------------------------
// pdsdc_in_if
// Input channel: measured and desired velocity.
// ----------------------------------------------------------------------------
interface pdsdc_in_if;
  logic valid;
  logic ready;
  logic signed [pdsdc_pkg::VelW-1:0] meas_x;
  logic signed [pdsdc_pkg::VelW-1:0] meas_y;
  logic signed [pdsdc_pkg::VelW-1:0] meas_z;
  logic signed [pdsdc_pkg::VelW-1:0] goal_x;
  logic signed [pdsdc_pkg::VelW-1:0] goal_y;
  logic signed [pdsdc_pkg::VelW-1:0] goal_z;

  modport source (output valid, meas_x, meas_y, meas_z, goal_x, goal_y, goal_z,
                  input ready);
  modport sink (input valid, meas_x, meas_y, meas_z, goal_x, goal_y, goal_z,
                output ready);
endinterface

>>> design/pdsdc_out_if.sv
// ----------------------------------------------------------------------------
// pdsdc_out_if
// Output channel: control force and saturation flag.
// ----------------------------------------------------------------------------
interface pdsdc_out_if;
  logic valid;
  logic ready;
  logic signed [pdsdc_pkg::ForceW-1:0] force_x;
  logic signed [pdsdc_pkg::ForceW-1:0] force_y;
  logic signed [pdsdc_pkg::ForceW-1:0] force_z;
  logic saturated;

  modport source (output valid, force_x, force_y, force_z, saturated, input ready);
  modport sink (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

>>> design/pdsdc_div.sv
// ----------------------------------------------------------------------------
// pdsdc_div
// Pipelined restoring divider, three lanes sharing one divisor. One quotient
// bit per register stage; the divisor travels with the lanes.
// ----------------------------------------------------------------------------
module pdsdc_div (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [pdsdc_pkg::NumW-1:0]      num_i [3],
  input  logic [pdsdc_pkg::RemW-1:0]      den_i,
  output logic [pdsdc_pkg::QuoW-1:0]      quo_o [3]
);

  localparam int unsigned Stages = pdsdc_pkg::DivStages;
  localparam int unsigned RemW   = pdsdc_pkg::RemW;
  localparam int unsigned QuoW   = pdsdc_pkg::QuoW;
  localparam int unsigned NumW   = pdsdc_pkg::NumW;

  logic [RemW-1:0] den_q [Stages];
  logic [RemW-1:0] rem_q [Stages][3];
  // upper part: dividend bits still to shift in; low part: quotient bits
  logic [QuoW-1:0] low_q [Stages][3];

  for (genvar k = 0; k < Stages; k++) begin : g_stage
    logic [RemW-1:0] den_in;

    if (k == 0) begin : g_first
      assign den_in = den_i;
    end else begin : g_next
      assign den_in = den_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) den_q[k] <= den_in;
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RemW-1:0] rem_in;
      logic [QuoW-1:0] low_in;
      logic [RemW:0]   trial;
      logic            ge;

      if (k == 0) begin : g_first
        assign rem_in = RemW'(num_i[l][NumW-1:QuoW]);
        assign low_in = num_i[l][QuoW-1:0];
      end else begin : g_next
        assign rem_in = rem_q[k-1][l];
        assign low_in = low_q[k-1][l];
      end

      // trial subtract of the divisor
      assign trial = {rem_in, low_in[QuoW-1]};
      assign ge    = (trial >= {1'b0, den_in});

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? RemW'(trial - {1'b0, den_in}) : trial[RemW-1:0];
          low_q[k][l] <= {low_in[QuoW-2:0], ge};
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = low_q[Stages-1][l];
  end

endmodule

>>> design/passive_ds_damping_control.sv
// Pipeline: 44 register stages from input transfer to output valid (4 front,
//   37 divider, 3 back); the 37 comes from one quotient bit per stage.
// Throughput: one item per cycle; the whole pipeline advances unless a held
//   output result is not taken.
// Reset: valid bits clear and both gains return to 100.0 (Q12.12).
// ----------------------------------------------------------------------------
// passive_ds_damping_control
// Passive DS controller: force = -D*v + gain_along*d, with D having
// gain_along along d and gain_across across d; identity when d is zero.
// ----------------------------------------------------------------------------
module passive_ds_damping_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdsdc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [pdsdc_pkg::GainW-1:0]    cfg_data_i,
  pdsdc_in_if.sink                       in_i,
  pdsdc_out_if.source                    out_o
);

  localparam int unsigned VelW   = pdsdc_pkg::VelW;
  localparam int unsigned GainW  = pdsdc_pkg::GainW;
  localparam int unsigned ProdW  = pdsdc_pkg::ProdW;
  localparam int unsigned WW     = pdsdc_pkg::WW;
  localparam int unsigned WAbsW  = pdsdc_pkg::WAbsW;
  localparam int unsigned SW     = pdsdc_pkg::SW;
  localparam int unsigned NumW   = pdsdc_pkg::NumW;
  localparam int unsigned QuoW   = pdsdc_pkg::QuoW;
  localparam int unsigned AccW   = pdsdc_pkg::AccW;
  localparam int unsigned ForceW = pdsdc_pkg::ForceW;
  localparam int unsigned Stages = pdsdc_pkg::DivStages;
  localparam int unsigned HalfW  = WAbsW / 2;
  localparam int unsigned PLoW   = 19;
  localparam int unsigned PW     = QuoW + 1;

  localparam logic signed [AccW-1:0] OutMax = AccW'((64'sd1 <<< (ForceW - 1)) - 1);
  localparam logic signed [AccW-1:0] OutMin = -(AccW'(64'sd1 <<< (ForceW - 1)));
  localparam logic signed [AccW-1:0] Half   = AccW'(64'sd1 <<< 23);

  // --------------------------------------------------------------------------
  // Configuration registers; zero writes and unknown indexes are dropped
  // --------------------------------------------------------------------------
  logic [GainW-1:0] gain_along_q, gain_across_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_along_q  <= pdsdc_pkg::GainReset;
      gain_across_q <= pdsdc_pkg::GainReset;
    end else if (cfg_we_i && (cfg_data_i != '0)) begin
      unique case (cfg_idx_i)
        pdsdc_pkg::RegGainAlong:  gain_along_q  <= cfg_data_i;
        pdsdc_pkg::RegGainAcross: gain_across_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [GainW:0] la, lc, dl;
  assign la = signed'({1'b0, gain_along_q});
  assign lc = signed'({1'b0, gain_across_q});
  assign dl = la - lc;

  // --------------------------------------------------------------------------
  // Flow control: global advance unless a result is held
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_o.ready;
  assign in_i.ready  = en;

  logic v1_q, v2_q, v3_q, v4_q, va_q, vb_q;
  logic vdiv_q [Stages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      va_q <= 1'b0; vb_q <= 1'b0; out_valid_q <= 1'b0;
      for (int k = 0; k < Stages; k++) vdiv_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vdiv_q[0] <= v4_q;
      for (int k = 1; k < Stages; k++) vdiv_q[k] <= vdiv_q[k-1];
      va_q <= vdiv_q[Stages-1];
      vb_q <= va_q;
      out_valid_q <= vb_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture, component products
  // --------------------------------------------------------------------------
  logic signed [VelW-1:0] meas_in [3], goal_in [3];
  assign meas_in[0] = in_i.meas_x;
  assign meas_in[1] = in_i.meas_y;
  assign meas_in[2] = in_i.meas_z;
  assign goal_in[0] = in_i.goal_x;
  assign goal_in[1] = in_i.goal_y;
  assign goal_in[2] = in_i.goal_z;

  pdsdc_pkg::side_t       s1_q, s2_q, s3_q, s4_q;
  logic signed [ProdW-1:0] dv_q [3];
  logic [SW-2:0]           dd_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_q.meas[i] <= meas_in[i];
        s1_q.goal[i] <= goal_in[i];
        dv_q[i]      <= ProdW'(meas_in[i] * goal_in[i]);
        dd_q[i]      <= (SW-1)'(goal_in[i] * goal_in[i]);
      end
      s1_q.neg  <= '0;
      s1_q.zero <= (goal_in[0] == '0) && (goal_in[1] == '0) && (goal_in[2] == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: dot product d.v and squared norm
  // --------------------------------------------------------------------------
  logic signed [WW-1:0] w_d;
  logic [WAbsW-1:0]     wabs_q;
  logic                 wneg_q;
  logic [SW-1:0]        s2_den_q, s3_den_q, s4_den_q;

  assign w_d = WW'(dv_q[0]) + WW'(dv_q[1]) + WW'(dv_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q     <= s1_q;
      wneg_q   <= w_d[WW-1];
      wabs_q   <= w_d[WW-1] ? WAbsW'(-w_d) : WAbsW'(w_d);
      s2_den_q <= SW'(dd_q[0]) + SW'(dd_q[1]) + SW'(dd_q[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: |d_i| * |w| as two half products
  // --------------------------------------------------------------------------
  logic [ProdW-1:0] plo_q [3], phi_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [2:0] negv;
      negv = '0;
      for (int i = 0; i < 3; i++) begin
        logic [VelW-1:0] dabs;
        dabs = s2_q.goal[i][VelW-1] ? VelW'(-s2_q.goal[i]) : s2_q.goal[i];
        plo_q[i] <= ProdW'(dabs * wabs_q[HalfW-1:0]);
        phi_q[i] <= ProdW'(dabs * wabs_q[WAbsW-1:HalfW]);
        negv[i]  = s2_q.goal[i][VelW-1] ^ wneg_q;
      end
      s3_q     <= '{meas: s2_q.meas, goal: s2_q.goal, neg: negv, zero: s2_q.zero};
      s3_den_q <= s2_den_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: merge halves, scale by 2^12 into the dividend
  // --------------------------------------------------------------------------
  logic [NumW-1:0] num_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q     <= s3_q;
      s4_den_q <= s3_den_q;
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= ((NumW'(phi_q[i]) << HalfW) + NumW'(plo_q[i])) << 12;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: projection magnitude |d_i*w|*2^12 / |d|^2
  // --------------------------------------------------------------------------
  logic [QuoW-1:0] quo [3];

  pdsdc_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (num_q),
    .den_i (s4_den_q),
    .quo_o (quo)
  );

  pdsdc_pkg::side_t sdiv_q [Stages];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sdiv_q[0] <= s4_q;
      for (int k = 1; k < Stages; k++) sdiv_q[k] <= sdiv_q[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: signed projection times gain difference, gain products
  // --------------------------------------------------------------------------
  pdsdc_pkg::side_t       sa_q, sb_q;
  logic signed [GainW+PLoW:0]        ppl_q [3];
  logic signed [GainW+PW-PLoW:0]     pph_q [3];
  logic signed [GainW+VelW:0]        ld_q [3], cv_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= sdiv_q[Stages-1];
      for (int i = 0; i < 3; i++) begin
        logic signed [PW-1:0] p;
        p = sdiv_q[Stages-1].neg[i] ? -signed'({1'b0, quo[i]}) : signed'({1'b0, quo[i]});
        ppl_q[i] <= (GainW+PLoW+1)'(dl * signed'({1'b0, p[PLoW-1:0]}));
        pph_q[i] <= (GainW+PW-PLoW+1)'(dl * signed'(p[PW-1:PLoW]));
        ld_q[i]  <= (GainW+VelW+1)'(la * signed'(sdiv_q[Stages-1].goal[i]));
        cv_q[i]  <= (GainW+VelW+1)'(lc * signed'(sdiv_q[Stages-1].meas[i]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: accumulate in units of 2^-40
  // --------------------------------------------------------------------------
  logic signed [AccW-1:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q <= sa_q;
      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= ((AccW'(ld_q[i]) - AccW'(cv_q[i])) <<< 12)
                    - ((AccW'(pph_q[i]) <<< PLoW) + AccW'(ppl_q[i]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: round to Q24.16, clamp, zero-goal bypass
  // --------------------------------------------------------------------------
  logic signed [ForceW-1:0] force_q [3];
  logic                     sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      logic sat;
      sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
        logic signed [AccW-1:0] f;
        f = (acc_q[i] + Half) >>> 24;
        if (sb_q.zero) begin
          force_q[i] <= -(ForceW'(signed'(sb_q.meas[i])));
        end else if (f > OutMax) begin
          force_q[i] <= ForceW'(OutMax);
          sat = 1'b1;
        end else if (f < OutMin) begin
          force_q[i] <= ForceW'(OutMin);
          sat = 1'b1;
        end else begin
          force_q[i] <= ForceW'(f);
        end
      end
      sat_q <= sat;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.force_x   = force_q[0];
  assign out_o.force_y   = force_q[1];
  assign out_o.force_z   = force_q[2];
  assign out_o.saturated = sat_q;

endmodule

>>> design/pdsdc_checker.sv
// ----------------------------------------------------------------------------
// pdsdc_checker
// Port-level checks of the damping controller, bound to the top level.
// ----------------------------------------------------------------------------
module pdsdc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [pdsdc_pkg::ForceW-1:0]   force_x_i,
  input logic                           saturated_i
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // a held result keeps its x force and saturation flag
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(force_x_i) && $stable(saturated_i))
    else $error("output payload changed while stalled");

  // input side only backs up when the output holds a result
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output backpressure");

  // 24-bit inputs never reach the 40-bit clamp
  a_no_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !saturated_i)
    else $error("force clamp hit");

endmodule

bind passive_ds_damping_control pdsdc_checker u_pdsdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .force_x_i   (out_o.force_x),
  .saturated_i (out_o.saturated)
);

>>> dv/passive_ds_damping_control_checker.sv
// ----------------------------------------------------------------------------
// passive_ds_damping_control_checker
// Watches the velocity and force channels, predicts the force of every
// accepted velocity transfer and compares it field by field in order.
// ----------------------------------------------------------------------------
module passive_ds_damping_control_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [pdsdc_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [pdsdc_pkg::GainW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic signed [pdsdc_pkg::VelW-1:0] meas_x_i, meas_y_i, meas_z_i,
  input  logic signed [pdsdc_pkg::VelW-1:0] goal_x_i, goal_y_i, goal_z_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic signed [pdsdc_pkg::ForceW-1:0] force_x_i, force_y_i, force_z_i,
  input  logic                saturated_i,
  output int                  errors_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VelW   = pdsdc_pkg::VelW;
  localparam int unsigned GainW  = pdsdc_pkg::GainW;
  localparam int unsigned ForceW = pdsdc_pkg::ForceW;

  typedef struct packed {
    logic signed [ForceW-1:0] fx;
    logic signed [ForceW-1:0] fy;
    logic signed [ForceW-1:0] fz;
    logic                     sat;
  } force_t;

  force_t       force_q[$];
  logic [GainW-1:0] along_gain, across_gain;

  // Exact projection-based damping force
  function automatic force_t damp_force(input logic signed [VelW-1:0] v[3],
                                        input logic signed [VelW-1:0] d[3]);
    force_t r;
    logic signed [127:0] w, s, p, acc, f, num, q;
    logic signed [127:0] la, lc;
    logic signed [127:0] lim_hi, lim_lo;
    logic signed [ForceW-1:0] fo[3];
    logic sat;
    sat = 1'b0;
    lim_hi = (128'sd1 <<< (ForceW-1)) - 1;
    lim_lo = -(128'sd1 <<< (ForceW-1));
    la = $signed({104'd0, along_gain});
    lc = $signed({104'd0, across_gain});
    w = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      w += 128'(d[i]) * 128'(v[i]);
      s += 128'(d[i]) * 128'(d[i]);
    end
    for (int i = 0; i < 3; i++) begin
      if (s == 0) f = -128'(v[i]);
      else begin
        num = 128'(d[i]) * w * 4096;
        // Truncate toward zero on magnitudes
        q = (num < 0 ? -num : num) / s;
        p = (num < 0) ? -q : q;
        acc = 4096 * (la * 128'(d[i]) - lc * 128'(v[i])) - (la - lc) * p;
        f = (acc + (128'sd1 <<< 23)) >>> 24;
      end
      if (f > lim_hi) begin f = lim_hi; sat = 1'b1; end
      if (f < lim_lo) begin f = lim_lo; sat = 1'b1; end
      fo[i] = f[ForceW-1:0];
    end
    r.fx = fo[0];
    r.fy = fo[1];
    r.fz = fo[2];
    r.sat = sat;
    return r;
  endfunction

  assign pending_o = force_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [VelW-1:0] v[3], d[3];
    force_t want, got;
    if (!rst_ni) begin
      along_gain  <= pdsdc_pkg::GainReset;
      across_gain <= pdsdc_pkg::GainReset;
      errors_o    <= 0;
      force_q.delete();
    end else begin
      // Output transfer check
      if (out_valid_i && out_ready_i) begin
        got = '{force_x_i, force_y_i, force_z_i, saturated_i};
        if (force_q.size() == 0) begin
          $display("%0t: unexpected force transfer %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          want = force_q.pop_front();
          if (want.fx !== got.fx || want.fy !== got.fy || want.fz !== got.fz ||
              want.sat !== got.sat) begin
            $display("%0t: force mismatch exp x=%0d y=%0d z=%0d sat=%0b", $time,
                     want.fx, want.fy, want.fz, want.sat);
            $display("%0t:                 act x=%0d y=%0d z=%0d sat=%0b", $time,
                     got.fx, got.fy, got.fz, got.sat);
            errors_o <= errors_o + 1;
          end
        end
      end
      // Input transfer predicts with gains before this edge's write
      if (in_valid_i && in_ready_i) begin
        v = '{meas_x_i, meas_y_i, meas_z_i};
        d = '{goal_x_i, goal_y_i, goal_z_i};
        force_q.push_back(damp_force(v, d));
      end
      // Gain writes; zero and unknown indexes ignored
      if (cfg_we_i && cfg_data_i != '0) begin
        if (cfg_idx_i == pdsdc_pkg::RegGainAlong) along_gain <= cfg_data_i;
        else if (cfg_idx_i == pdsdc_pkg::RegGainAcross) across_gain <= cfg_data_i;
      end
    end
  end
endmodule

>>> dv/passive_ds_damping_control_tb.sv
// ----------------------------------------------------------------------------
// passive_ds_damping_control_tb
// Drives velocity pairs and gain settings into the damping controller with
// random idling on both channels; the checker predicts and compares forces.
// ----------------------------------------------------------------------------
module passive_ds_damping_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdxW  = pdsdc_pkg::IdxW;
  localparam int unsigned GainW = pdsdc_pkg::GainW;
  localparam int unsigned VelW  = pdsdc_pkg::VelW;

  localparam int Latency  = 44;
  localparam int WatchMax = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IdxW-1:0]  cfg_idx_i = '0;
  logic [GainW-1:0] cfg_data_i = '0;
  int errors, pending, stall_cycles;
  bit calm;

  pdsdc_in_if  vel_ch ();
  pdsdc_out_if frc_ch ();

  passive_ds_damping_control DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(vel_ch.sink), .out_o(frc_ch.source)
  );

  passive_ds_damping_control_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i(vel_ch.valid), .in_ready_i(vel_ch.ready),
    .meas_x_i(vel_ch.meas_x), .meas_y_i(vel_ch.meas_y), .meas_z_i(vel_ch.meas_z),
    .goal_x_i(vel_ch.goal_x), .goal_y_i(vel_ch.goal_y), .goal_z_i(vel_ch.goal_z),
    .out_valid_i(frc_ch.valid), .out_ready_i(frc_ch.ready),
    .force_x_i(frc_ch.force_x), .force_y_i(frc_ch.force_y),
    .force_z_i(frc_ch.force_z), .saturated_i(frc_ch.saturated),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    vel_ch.valid = 1'b0;
    {vel_ch.meas_x, vel_ch.meas_y, vel_ch.meas_z} = '0;
    {vel_ch.goal_x, vel_ch.goal_y, vel_ch.goal_z} = '0;
    frc_ch.ready = 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((vel_ch.valid && vel_ch.ready) || (frc_ch.valid && frc_ch.ready))
      stall_cycles <= 0;
    else if (rst_ni) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchMax) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Force receiver with random stalls
  always @(negedge clk_i) begin
    frc_ch.ready <= calm || ($urandom_range(99) >= 37);
  end

  function automatic logic [VelW-1:0] rand_vel();
    case ($urandom_range(5))
      0: rand_vel = 24'h7FFFFF;
      1: rand_vel = 24'h800000;
      2: rand_vel = '0;
      3: rand_vel = VelW'($urandom_range(255)) - 24'd128;
      default: rand_vel = VelW'($urandom);
    endcase
  endfunction

  // Valid stays high between back-to-back items; it drops only while idling
  task automatic send_vel(input logic [VelW-1:0] mx, my, mz, gx, gy, gz);
    while (!calm && $urandom_range(99) < 37) begin
      vel_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    vel_ch.valid  <= 1'b1;
    vel_ch.meas_x <= mx; vel_ch.meas_y <= my; vel_ch.meas_z <= mz;
    vel_ch.goal_x <= gx; vel_ch.goal_y <= gy; vel_ch.goal_z <= gz;
    @(posedge clk_i);
    while (!vel_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Gain writes only with the pipeline empty
  task automatic write_gain(input logic [IdxW-1:0] idx, input logic [GainW-1:0] val);
    vel_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (Latency + 4) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      calm = (k >= n / 2 && k < n / 2 + 60);
      send_vel(rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel(), rand_vel());
    end
    calm = 1'b0;
  endtask

  initial begin
    int wait_cycles;
    calm = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    // Directed: reset gains, extremes, zero goal
    send_vel(24'h7FFFFF, 24'h800000, 24'h000001, 24'h000000, 24'h000000, 24'h000000);
    send_vel(24'h800000, 24'h800000, 24'h800000, 24'h000000, 24'h000000, 24'h000000);
    send_vel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000);
    send_vel(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
    send_vel(24'h000001, 24'hFFFFFF, 24'h000000, 24'h000001, 24'h000000, 24'h000000);
    send_vel(24'h123456, 24'hABCDEF, 24'h555555, 24'h000000, 24'hFFFFFF, 24'h000000);
    send_vel(24'h000000, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
    // Extreme gains, plus ignored zero and unknown-index writes
    write_gain(pdsdc_pkg::RegGainAlong, 24'hFFFFFF);
    write_gain(pdsdc_pkg::RegGainAcross, 24'h000001);
    write_gain(pdsdc_pkg::RegGainAlong, 24'h000000);
    write_gain(2'd3, 24'h000005);
    send_vel(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_vel(24'h800000, 24'h800000, 24'h800000, 24'h7FFFFF, 24'h000001, 24'h800000);
    send_vel(24'h7FFFFF, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000);
    write_gain(pdsdc_pkg::RegGainAlong, 24'h000001);
    write_gain(pdsdc_pkg::RegGainAcross, 24'hFFFFFF);
    send_vel(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000);
    send_vel(24'h800000, 24'h7FFFFF, 24'h000001, 24'h000003, 24'hFFFFFD, 24'h000007);
    random_phase(300);
    // Random gain settings between phases
    for (int ph = 0; ph < 3; ph++) begin
      write_gain(pdsdc_pkg::RegGainAlong, GainW'($urandom_range(24'hFFFFFF, 1)));
      write_gain(pdsdc_pkg::RegGainAcross, GainW'($urandom_range(24'hFFFFFF, 1)));
      random_phase(330);
    end
    // Drain
    vel_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < WatchMax) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (Latency + 10) @(negedge clk_i);
    if (errors == 0 && pending == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> files.f
design/pdsdc_pkg.sv
design/pdsdc_in_if.sv
design/pdsdc_out_if.sv
design/pdsdc_div.sv
design/passive_ds_damping_control.sv
design/pdsdc_checker.sv
dv/passive_ds_damping_control_checker.sv
dv/passive_ds_damping_control_tb.sv
